// ===== src/gdfw_pkg.sv =====
package gdfw_pkg;

  localparam int VTX_W            = 6;
  localparam int CNT_W            = 7;
  localparam int OP_W             = 2;
  localparam int DEF_MAX_VERTICES = 64;
  localparam int IN_TDATA_W       = ((2 * VTX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W      = ((VTX_W + 7) / 8) * 8;
  localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_EDGE  = 2'd1,
    OP_WALK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic edge_start;
    logic edge_wr1;
    logic edge_wr2;
    logic walk_start;
    logic walk_push;
    logic walk_pop;
    logic walk_pop_row;
    logic walk_end;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic start_ok;
    logic edge_ok;
    logic same_ends;
    logic cand_any;
    logic depth_one;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

// ===== src/gdfw_ctrl.sv =====
module gdfw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  gdfw_pkg::op_t    in_opcode,
  input  gdfw_pkg::sts_t   sts,
  output logic             in_tready,
  output gdfw_pkg::cmd_t   cmd
);
  import gdfw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_EDGE1,
    S_EDGE2,
    S_SCAN,
    S_POP
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_opcode)
            OP_CLEAR: begin
              if (!sts.n_zero) begin
                cmd.clr_start = 1'b1;
                state_nxt     = S_CLR;
              end
            end
            OP_EDGE: begin
              if (sts.edge_ok) begin
                cmd.edge_start = 1'b1;
                state_nxt      = S_EDGE1;
              end
            end
            OP_WALK: begin
              if (sts.start_ok) begin
                cmd.walk_start = 1'b1;
                state_nxt      = S_SCAN;
              end
            end
            OP_NOP: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_EDGE1: begin
        cmd.edge_wr1 = 1'b1;
        state_nxt    = sts.same_ends ? S_IDLE : S_EDGE2;
      end
      S_EDGE2: begin
        cmd.edge_wr2 = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_SCAN: begin
        if (sts.cand_any) begin
          cmd.walk_push = sts.out_free;
        end else if (sts.depth_one) begin
          if (sts.out_free) begin
            cmd.walk_end = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.walk_pop = 1'b1;
          state_nxt    = S_POP;
        end
      end
      S_POP: begin
        cmd.walk_pop_row = 1'b1;
        state_nxt        = S_SCAN;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/gdfw_dp.sv =====
module gdfw_dp #(
  parameter int MAX_VERTICES = gdfw_pkg::DEF_MAX_VERTICES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [gdfw_pkg::CNT_W-1:0]   cfg_data,
  input  logic [gdfw_pkg::VTX_W-1:0]   in_first,
  input  logic [gdfw_pkg::VTX_W-1:0]   in_second,
  input  gdfw_pkg::cmd_t               cmd,
  output gdfw_pkg::sts_t               sts,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [gdfw_pkg::VTX_W-1:0]   out_vertex,
  output logic                         out_last
);
  import gdfw_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [CNT_W-1:0]        vcount_r;
  logic [CW-1:0]           n;
  logic [MAX_VERTICES-1:0] act_mask;

  logic [VW-1:0]           op_a_r, op_b_r;
  logic [VW-1:0]           in_a_idx, in_b_idx;
  logic [VW-1:0]           clr_idx_r;
  logic [CW-1:0]           depth_r;
  logic [MAX_VERTICES-1:0] visited_r;
  logic [VW-1:0]           pend_r;
  logic                    out_valid_r, out_last_r;
  logic [VW-1:0]           out_vtx_r;

  logic [MAX_VERTICES-1:0] row_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld_r;
  logic [MAX_VERTICES-1:0] row_q_r;
  logic                    row_rd_en, row_wr_en;
  logic [VW-1:0]           row_rd_addr, row_wr_addr;
  logic [MAX_VERTICES-1:0] row_wr_data;

  logic [VW-1:0]           stk_mem [MAX_VERTICES];
  logic [VW-1:0]           stk_q_r;
  logic                    stk_wr_en;
  logic [VW-1:0]           stk_wr_addr, stk_wr_data, stk_rd_addr;

  logic [MAX_VERTICES-1:0] cand;
  logic [VW-1:0]           ffs_idx;

  assign n = (32'(vcount_r) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vcount_r);

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      act_mask[j] = (j < int'(n));
    end
  end

  assign in_a_idx = VW'(in_first);
  assign in_b_idx = VW'(in_second);

  assign cand = row_q_r & ~visited_r & act_mask;

  always_comb begin
    ffs_idx = '0;
    for (int j = MAX_VERTICES - 1; j >= 0; j--) begin
      if (cand[j]) begin
        ffs_idx = VW'(j);
      end
    end
  end

  assign sts.n_zero    = (n == '0);
  assign sts.start_ok  = (32'(in_first) < 32'(n));
  assign sts.edge_ok   = (32'(in_first) < MAX_VERTICES) && (32'(in_second) < MAX_VERTICES);
  assign sts.same_ends = (op_a_r == op_b_r);
  assign sts.cand_any  = |cand;
  assign sts.depth_one = (depth_r == CW'(1));
  assign sts.idx_last  = ((32'(clr_idx_r) + 32'd1) == 32'(n));
  assign sts.out_free  = !out_valid_r || out_tready;

  always_comb begin
    row_rd_en   = 1'b1;
    row_rd_addr = '0;
    row_wr_en   = 1'b0;
    row_wr_addr = clr_idx_r;
    row_wr_data = row_q_r & ~act_mask;
    if (cmd.clr_start) begin
      row_rd_addr = '0;
    end else if (cmd.clr_step) begin
      row_rd_addr = clr_idx_r + VW'(1);
      row_wr_en   = 1'b1;
    end else if (cmd.edge_start || cmd.walk_start) begin
      row_rd_addr = in_a_idx;
    end else if (cmd.edge_wr1) begin
      row_rd_addr = op_b_r;
      row_wr_en   = 1'b1;
      row_wr_addr = op_a_r;
      row_wr_data = row_q_r | (MAX_VERTICES'(1) << op_b_r);
    end else if (cmd.edge_wr2) begin
      row_rd_en   = 1'b0;
      row_wr_en   = 1'b1;
      row_wr_addr = op_b_r;
      row_wr_data = row_q_r | (MAX_VERTICES'(1) << op_a_r);
    end else if (cmd.walk_push) begin
      row_rd_addr = ffs_idx;
    end else if (cmd.walk_pop_row) begin
      row_rd_addr = stk_q_r;
    end else begin
      row_rd_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_wr_en) begin
      row_mem[row_wr_addr] <= row_wr_data;
    end
    if (row_rd_en) begin
      row_q_r <= row_vld_r[row_rd_addr] ? row_mem[row_rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (row_wr_en) begin
      row_vld_r[row_wr_addr] <= 1'b1;
    end
  end

  assign stk_wr_en   = cmd.walk_start || cmd.walk_push;
  assign stk_wr_addr = cmd.walk_start ? '0 : depth_r[VW-1:0];
  assign stk_wr_data = cmd.walk_start ? in_a_idx : ffs_idx;
  assign stk_rd_addr = VW'(depth_r - CW'(2));

  always_ff @(posedge clk) begin
    if (stk_wr_en) begin
      stk_mem[stk_wr_addr] <= stk_wr_data;
    end
    if (cmd.walk_pop) begin
      stk_q_r <= stk_mem[stk_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_start) begin
      op_a_r <= in_a_idx;
      op_b_r <= in_b_idx;
    end
    if (cmd.walk_start) begin
      pend_r <= in_a_idx;
    end else if (cmd.walk_push) begin
      pend_r <= ffs_idx;
    end
    if (cmd.walk_push || cmd.walk_end) begin
      out_vtx_r  <= pend_r;
      out_last_r <= cmd.walk_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= VCOUNT_RESET;
      clr_idx_r   <= '0;
      depth_r     <= '0;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        vcount_r <= cfg_data;
      end
      if (cmd.clr_start) begin
        clr_idx_r <= '0;
      end else if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + VW'(1);
      end
      if (cmd.walk_start) begin
        depth_r   <= CW'(1);
        visited_r <= MAX_VERTICES'(1) << in_a_idx;
      end else if (cmd.walk_push) begin
        depth_r   <= depth_r + CW'(1);
        visited_r <= visited_r | (MAX_VERTICES'(1) << ffs_idx);
      end else if (cmd.walk_pop) begin
        depth_r <= depth_r - CW'(1);
      end else if (cmd.walk_end) begin
        depth_r <= '0;
      end
      if (cmd.walk_push || cmd.walk_end) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_vertex = VTX_W'(out_vtx_r);
  assign out_last   = out_last_r;

endmodule

// ===== src/graph_depth_first_walk.sv =====
// Clear rewrites each active row in turn; add edge writes both rows (one for a
// self edge); a walk pushes each vertex reached and backtracks by pop and fetch.
// One item is in work at a time; the single read port of the adjacency row
// memory and of the vertex stack memory sets the walk time.
// Reset (rst_n low, synchronous): adjacency rows read as zero through per-row
// valid bits, visited marks and stack depth clear, vertex count returns to 64.
module graph_depth_first_walk #(
  parameter int MAX_VERTICES = gdfw_pkg::DEF_MAX_VERTICES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gdfw_pkg::CNT_W-1:0]       cfg_data,    // vertex_count
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gdfw_pkg::IN_TDATA_W-1:0]  in_tdata,    // first_vertex, second_vertex
  input  logic [gdfw_pkg::OP_W-1:0]        in_tuser,    // opcode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gdfw_pkg::OUT_TDATA_W-1:0] out_tdata,   // visited_vertex
  output logic                             out_tlast
);
  import gdfw_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [VTX_W-1:0]  out_vertex;

  assign cfg_ready = 1'b1;

  gdfw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_opcode (op_t'(in_tuser)),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  gdfw_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_first   (in_tdata[VTX_W-1:0]),
    .in_second  (in_tdata[2*VTX_W-1:VTX_W]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_vertex (out_vertex),
    .out_last   (out_tlast)
  );

  assign out_tdata = OUT_TDATA_W'(out_vertex);

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_push |-> sts.out_free && sts.cand_any)
    else $error("push while output register is busy");

  a_end_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_end |-> sts.depth_one && sts.out_free && !sts.cand_any)
    else $error("walk ended with stack not at its base");

  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_pop |=> cmd.walk_pop_row)
    else $error("stack pop not followed by row fetch");

endmodule

// ===== test/graph_depth_first_walk_tb.sv =====
`timescale 1ns / 100ps

module graph_depth_first_walk_tb;
  import gdfw_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 300;
  localparam int IDLE_PCT      = 14;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             last;
  } visit_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CNT_W-1:0]       cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]        in_tuser   = OP_NOP;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  logic [DEF_MAX_VERTICES-1:0] adj_rows [DEF_MAX_VERTICES];
  logic [CNT_W-1:0]            vertex_count = VCOUNT_RESET;
  visit_t                      visit_order_q [$];
  visit_t                      next_visit;
  logic                        steady_run = 1'b0;

  int fail_count      = 0;
  int item_count      = 0;
  int walk_count      = 0;
  int visit_count     = 0;
  int cfg_write_count = 0;
  int cycle_count     = 0;
  int phase_count     = 0;

  graph_depth_first_walk DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    foreach (adj_rows[r]) adj_rows[r] = '0;
  end

  function automatic int active_vertices();
    return (vertex_count > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : int'(vertex_count);
  endfunction

  function automatic void clear_graph();
    int n;
    n = active_vertices();
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) adj_rows[r][c] = 1'b0;
  endfunction

  function automatic void predict_dfs_visits(logic [VTX_W-1:0] start);
    logic [VTX_W-1:0] stack_v [DEF_MAX_VERTICES];
    int               stack_i [DEF_MAX_VERTICES];
    logic [DEF_MAX_VERTICES-1:0] seen;
    logic [VTX_W-1:0] order [$];
    int n, depth, v, i;
    n = active_vertices();
    if (int'(start) >= n) return;
    seen = '0;
    seen[start] = 1'b1;
    order.push_back(start);
    stack_v[0] = start;
    stack_i[0] = 0;
    depth = 1;
    while (depth > 0) begin
      v = stack_v[depth-1];
      i = stack_i[depth-1];
      while (i < n && !(adj_rows[v][i] && !seen[i])) i++;
      if (i < n && depth < DEF_MAX_VERTICES) begin
        stack_i[depth-1] = i + 1;
        seen[i] = 1'b1;
        order.push_back(VTX_W'(i));
        stack_v[depth] = VTX_W'(i);
        stack_i[depth] = 0;
        depth++;
      end else begin
        depth--;
      end
    end
    foreach (order[k])
      visit_order_q.push_back('{vertex: order[k], last: (k == order.size() - 1)});
  endfunction

  function automatic logic [VTX_W-1:0] pick_vertex();
    int n;
    n = active_vertices();
    if (n == 0 || $urandom_range(9) == 0) return VTX_W'($urandom_range(63));
    return VTX_W'($urandom_range(n - 1));
  endfunction

  task automatic send_item(op_t op, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b);
    while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({b, a});
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    item_count++;
    case (op)
      OP_CLEAR: clear_graph();
      OP_EDGE: begin
        adj_rows[a][b] = 1'b1;
        adj_rows[b][a] = 1'b1;
      end
      OP_WALK: begin
        walk_count++;
        predict_dfs_visits(a);
      end
      default: ;
    endcase
  endtask

  task automatic await_idle();
    in_tvalid <= 1'b0;
    while (visit_order_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [CNT_W-1:0] value);
    await_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    vertex_count = value;
    cfg_write_count++;
  endtask

  task automatic test_basic_walks();
    send_item(OP_WALK, 6'd0, 6'd0);
    send_item(OP_EDGE, 6'd0, 6'd63);
    send_item(OP_EDGE, 6'd63, 6'd62);
    send_item(OP_EDGE, 6'd62, 6'd0);
    send_item(OP_EDGE, 6'd5, 6'd5);
    send_item(OP_EDGE, 6'd0, 6'd42);
    send_item(OP_EDGE, 6'd21, 6'd42);
    send_item(OP_WALK, 6'd0, 6'd63);
    send_item(OP_WALK, 6'd63, 6'd0);
    send_item(OP_WALK, 6'd5, 6'd21);
    send_item(OP_NOP, 6'd63, 6'd63);
    send_item(OP_WALK, 6'd21, 6'd42);
    send_item(OP_CLEAR, 6'd0, 6'd0);
    send_item(OP_WALK, 6'd0, 6'd0);
  endtask

  task automatic test_vertex_count_limits();
    write_vertex_count(7'd0);
    send_item(OP_CLEAR, 6'd0, 6'd0);
    send_item(OP_EDGE, 6'd1, 6'd2);
    send_item(OP_WALK, 6'd0, 6'd0);
    write_vertex_count(7'd127);
    send_item(OP_WALK, 6'd1, 6'd0);
    write_vertex_count(7'd1);
    send_item(OP_WALK, 6'd0, 6'd0);
    send_item(OP_WALK, 6'd1, 6'd0);
    write_vertex_count(7'd10);
    send_item(OP_EDGE, 6'd3, 6'd40);
    send_item(OP_CLEAR, 6'd0, 6'd0);
    send_item(OP_WALK, 6'd3, 6'd0);
    write_vertex_count(7'd64);
    send_item(OP_WALK, 6'd40, 6'd0);
  endtask

  task automatic test_deep_chain();
    logic [VTX_W-1:0] path [DEF_MAX_VERTICES];
    logic [VTX_W-1:0] tmp;
    int j;
    foreach (path[k]) path[k] = VTX_W'(k);
    for (int k = DEF_MAX_VERTICES - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = path[k];
      path[k] = path[j];
      path[j] = tmp;
    end
    write_vertex_count(7'd64);
    send_item(OP_CLEAR, VTX_W'($urandom_range(63)), VTX_W'($urandom_range(63)));
    for (int k = 0; k < DEF_MAX_VERTICES - 1; k++) begin
      if ($urandom_range(1)) send_item(OP_EDGE, path[k], path[k+1]);
      else send_item(OP_EDGE, path[k+1], path[k]);
    end
    send_item(OP_WALK, path[0], VTX_W'($urandom_range(63)));
    send_item(OP_WALK, path[DEF_MAX_VERTICES/2], VTX_W'($urandom_range(63)));
    send_item(OP_WALK, path[DEF_MAX_VERTICES-1], VTX_W'($urandom_range(63)));
  endtask

  task automatic test_random_graphs();
    logic [CNT_W-1:0] counts [8] = '{7'd64, 7'd8, 7'd2, 7'd127, 7'd33, 7'd1, 7'd20, 7'd64};
    int r;
    op_t op;
    counts[6] = CNT_W'($urandom_range(3, 64));
    foreach (counts[p]) begin
      write_vertex_count(counts[p]);
      steady_run = (p == 3);
      phase_count++;
      if ($urandom_range(1)) send_item(OP_CLEAR, pick_vertex(), pick_vertex());
      for (int k = 0; k < 44; k++) begin
        r = $urandom_range(99);
        if (r < 5) op = OP_CLEAR;
        else if (r < 10) op = OP_NOP;
        else if (r < 38) op = OP_WALK;
        else op = OP_EDGE;
        if (op == OP_CLEAR || op == OP_NOP)
          send_item(op, VTX_W'($urandom_range(63)), VTX_W'($urandom_range(63)));
        else
          send_item(op, pick_vertex(), pick_vertex());
      end
    end
    steady_run = 1'b0;
  endtask

  always @(posedge clk) begin
    out_tready <= steady_run ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    if (rst_n && out_tvalid && out_tready) begin
      visit_count++;
      if (visit_order_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected visit: vertex %0d last %0b", out_tdata, out_tlast);
      end else begin
        next_visit = visit_order_q.pop_front();
        if (out_tdata !== OUT_TDATA_W'(next_visit.vertex) || out_tlast !== next_visit.last)
        begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("visit mismatch: expected vertex %0d last %0b, got vertex %0d last %0b",
                     next_visit.vertex, next_visit.last, out_tdata, out_tlast);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d visits outstanding",
             cycle_count, visit_order_q.size());
    $display("** graph_depth_first_walk: FAILED **");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_walks();
    test_vertex_count_limits();
    test_deep_chain();
    test_random_graphs();
    await_idle();
    if (visit_order_q.size() != 0) fail_count++;
    $display("Covered %0d items, %0d walks, %0d visits checked, %0d vertex count writes",
             item_count, walk_count, visit_count, cfg_write_count);
    $display("Included directed extremes, a full-depth chain walk and %0d random phases",
             phase_count);
    if (fail_count == 0) begin
      $display("** graph_depth_first_walk: PASSED **");
    end else begin
      $display("%0d failures", fail_count);
      $display("** graph_depth_first_walk: FAILED **");
    end
    $finish;
  end

endmodule
